// ===== hdl/assert_macros.svh =====
// ----------------------------------------------------------------------------
// Assertion macros
// Shared forms for concurrent checks on the clk/rst domain.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check that is switched off while reset is held.
`define CTU_ASSERT(name, prop, msg) \
  name: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Check that also holds during reset.
`define CTU_ASSERT_ALWAYS(name, prop, msg) \
  name: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ===== hdl/ctu2d_pkg.sv =====
// ----------------------------------------------------------------------------
// ctu2d_pkg
// Types and constants shared by the 2D collision test unit.
// ----------------------------------------------------------------------------
package ctu2d_pkg;

  localparam int CW        = 32;            // coordinate width
  localparam int FB        = 16;            // fraction bits
  localparam int PRE_SHIFT = 4;             // shift applied before squaring
  localparam int DW        = CW + 1;        // width of a difference or sum
  localparam int SW        = DW - PRE_SHIFT; // magnitude after the shift
  localparam int NQ        = FB + 1;        // quotient width, also the time width

  localparam logic [NQ-1:0] TOI_ONE = NQ'(1) << FB;

  localparam logic [2:0] CMD_CIRCLES      = 3'd0;
  localparam logic [2:0] CMD_BOXES        = 3'd1;
  localparam logic [2:0] CMD_POINT_BOX    = 3'd2;
  localparam logic [2:0] CMD_CIRCLE_BOX   = 3'd3;
  localparam logic [2:0] CMD_POINT_CIRCLE = 3'd4;
  localparam logic [2:0] CMD_SWEPT_X      = 3'd5;

  typedef struct packed {
    logic [2:0]           cmd;
    logic signed [CW-1:0] a_x;
    logic signed [CW-1:0] a_y;
    logic signed [CW-1:0] a_w;
    logic signed [CW-1:0] a_h;
    logic signed [CW-1:0] b_x;
    logic signed [CW-1:0] b_y;
    logic signed [CW-1:0] b_w;
    logic signed [CW-1:0] b_h;
  } ctu2d_req_t;

  typedef struct packed {
    logic          hit;
    logic [NQ-1:0] time_of_impact;
  } ctu2d_resp_t;

  typedef struct packed {
    logic valid;
    logic is_dist;
    logic is_swept;
    logic hit;
  } ctu2d_tag_t;

  // Classified request: for distance tests d0/d1 are the offsets and d2 the
  // radius term; for the swept test d0/d1 are entry and exit distances.
  typedef struct packed {
    logic                 is_dist;
    logic                 is_swept;
    logic                 hit;
    logic signed [DW-1:0] d0;
    logic signed [DW-1:0] d1;
    logic signed [DW-1:0] d2;
    logic [CW-1:0]        av;
  } ctu2d_job_t;

  typedef struct packed {
    logic full;
    logic empty;
  } ctu2d_qstat_t;

  function automatic logic signed [DW-1:0] ext_w(logic signed [CW-1:0] a);
    return $signed({a[CW-1], a});
  endfunction

  function automatic logic signed [DW-1:0] sub_w(logic signed [CW-1:0] a,
                                                 logic signed [CW-1:0] b);
    return ext_w(a) - ext_w(b);
  endfunction

  function automatic logic [DW-1:0] mag_w(logic signed [DW-1:0] v);
    logic [DW-1:0] m;
    m = v[DW-1] ? (~v + 1'b1) : v;
    return m;
  endfunction

endpackage

// ===== hdl/ctu2d_front.sv =====
// ----------------------------------------------------------------------------
// ctu2d_front
// Decodes a request and reduces it to the operands of its test.
// ----------------------------------------------------------------------------
module ctu2d_front import ctu2d_pkg::*; (
  input  ctu2d_req_t req,
  output ctu2d_job_t job
);

  logic signed [CW-1:0] cx;
  logic signed [CW-1:0] cy;

  always_comb begin
    // Nearest point of box B to the centre of A.
    if (req.a_x < req.b_x) begin
      cx = req.b_x;
    end else if (req.a_x > req.b_w) begin
      cx = req.b_w;
    end else begin
      cx = req.a_x;
    end
    if (req.a_y < req.b_y) begin
      cy = req.b_y;
    end else if (req.a_y > req.b_h) begin
      cy = req.b_h;
    end else begin
      cy = req.a_y;
    end

    job = '0;
    case (req.cmd)
      CMD_CIRCLES: begin
        job.is_dist = 1'b1;
        job.d0 = sub_w(req.b_x, req.a_x);
        job.d1 = sub_w(req.b_y, req.a_y);
        job.d2 = ext_w(req.a_w) + ext_w(req.b_w);
      end
      CMD_BOXES: begin
        job.hit = !(req.a_x >= req.b_w || req.a_w <= req.b_x ||
                    req.a_y >= req.b_h || req.a_h <= req.b_y);
      end
      CMD_POINT_BOX: begin
        job.hit = req.a_x >= req.b_x && req.a_x < req.b_w &&
                  req.a_y >= req.b_y && req.a_y < req.b_h;
      end
      CMD_CIRCLE_BOX: begin
        job.is_dist = 1'b1;
        job.d0 = sub_w(cx, req.a_x);
        job.d1 = sub_w(cy, req.a_y);
        job.d2 = ext_w(req.a_w);
      end
      CMD_POINT_CIRCLE: begin
        job.is_dist = 1'b1;
        job.d0 = sub_w(req.b_x, req.a_x);
        job.d1 = sub_w(req.b_y, req.a_y);
        job.d2 = ext_w(req.b_w);
      end
      CMD_SWEPT_X: begin
        job.is_swept = 1'b1;
        // a_y carries the x velocity here.
        if (req.a_y > 0) begin
          job.d0 = sub_w(req.b_x, req.a_w);
          job.d1 = sub_w(req.b_w, req.a_x);
        end else begin
          job.d0 = sub_w(req.b_w, req.a_x);
          job.d1 = sub_w(req.b_x, req.a_w);
        end
        job.av = req.a_y[CW-1] ? (~req.a_y + 1'b1) : req.a_y;
      end
      default: begin
        job = '0;
      end
    endcase
  end

endmodule

// ===== hdl/ctu2d_queue.sv =====
// ----------------------------------------------------------------------------
// ctu2d_queue
// Short first-in first-out queue of classified requests.
// ----------------------------------------------------------------------------
module ctu2d_queue import ctu2d_pkg::*; #(
  parameter int DEPTH = 4
) (
  input  logic         clk,
  input  logic         rst,
  input  logic         push,
  input  ctu2d_job_t   push_data,
  input  logic         pop,
  output ctu2d_job_t   pop_data,
  output ctu2d_qstat_t stat
);

  localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNTW = $clog2(DEPTH + 1);

  ctu2d_job_t      slots [DEPTH];
  logic [AW-1:0]   wptr;
  logic [AW-1:0]   rptr;
  logic [CNTW-1:0] count;

  assign stat.full  = (count == CNTW'(DEPTH));
  assign stat.empty = (count == '0);
  assign pop_data   = slots[rptr];

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wptr] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wptr  <= '0;
      rptr  <= '0;
      count <= '0;
    end else begin
      if (push) begin
        wptr <= (wptr == AW'(DEPTH - 1)) ? '0 : wptr + 1'b1;
      end
      if (pop) begin
        rptr <= (rptr == AW'(DEPTH - 1)) ? '0 : rptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

// ===== hdl/ctu2d_back.sv =====
// ----------------------------------------------------------------------------
// ctu2d_back
// Evaluation pipeline: squares for distance tests, restoring division with
// one quotient bit per stage for the swept test, and the result register.
// ----------------------------------------------------------------------------
module ctu2d_back import ctu2d_pkg::*; (
  input  logic         clk,
  input  logic         rst,
  input  ctu2d_job_t   job,
  input  ctu2d_qstat_t qstat,
  output logic         pop,
  output logic         out_valid,
  input  logic         out_ready,
  output ctu2d_resp_t  out_data
);

  logic en;

  // Preparation stage.
  ctu2d_tag_t    p_tag;
  logic [SW-1:0] p_mdx, p_mdy, p_mr;
  logic [DW-1:0] p_me, p_mx;
  logic [CW-1:0] p_av;
  logic          p_sat_e, p_sat_x;

  // Squares, aligned with the first divider stage.
  logic [2*SW-1:0] sq_x, sq_y, sq_r;

  // Divider stages.
  ctu2d_tag_t    d_tag  [NQ];
  logic [DW-1:0] d_re   [NQ];
  logic [DW-1:0] d_rx   [NQ];
  logic [NQ-1:0] d_qe   [NQ];
  logic [NQ-1:0] d_qx   [NQ];
  logic [CW-1:0] d_av   [NQ];
  logic          d_se   [NQ];
  logic          d_sx   [NQ];

  ctu2d_tag_t    t1_in;
  logic          dist_ok;
  logic [DW-1:0] j_me, j_mx;
  logic [DW-1:0] j_sx, j_sy, j_sr;
  logic          te_late;
  logic [NQ-1:0] toi;

  assign en  = !out_valid || out_ready;
  assign pop = en && !qstat.empty;

  always_comb begin
    j_me = mag_w(job.d0);
    j_mx = mag_w(job.d1);
    j_sx = mag_w(job.d0 >>> PRE_SHIFT);
    j_sy = mag_w(job.d1 >>> PRE_SHIFT);
    j_sr = mag_w(job.d2 >>> PRE_SHIFT);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      p_tag <= '0;
    end else if (en) begin
      p_tag.valid    <= pop;
      p_tag.is_dist  <= job.is_dist;
      p_tag.is_swept <= job.is_swept;
      p_tag.hit      <= job.hit;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      p_mdx   <= j_sx[SW-1:0];
      p_mdy   <= j_sy[SW-1:0];
      p_mr    <= j_sr[SW-1:0];
      p_me    <= j_me;
      p_mx    <= j_mx;
      p_av    <= job.av;
      // A quotient of two or more, or a zero velocity, saturates.
      p_sat_e <= j_me >= {job.av, 1'b0};
      p_sat_x <= j_mx >= {job.av, 1'b0};
      sq_x    <= p_mdx * p_mdx;
      sq_y    <= p_mdy * p_mdy;
      sq_r    <= p_mr * p_mr;
    end
  end

  assign dist_ok = ({1'b0, sq_x} + {1'b0, sq_y}) <= {1'b0, sq_r};

  always_comb begin
    t1_in = d_tag[0];
    if (d_tag[0].is_dist) begin
      t1_in.hit = dist_ok;
    end
  end

  for (genvar g = 0; g < NQ; g++) begin : g_div
    ctu2d_tag_t    tag_in;
    logic [DW-1:0] re_in, rx_in;
    logic [NQ-1:0] qe_in, qx_in;
    logic [CW-1:0] av_in;
    logic          se_in, sx_in;
    logic [DW-1:0] avx;
    logic          ge_e, ge_x;

    if (g == 0) begin : g_first
      assign tag_in = p_tag;
      assign re_in  = p_me;
      assign rx_in  = p_mx;
      assign qe_in  = '0;
      assign qx_in  = '0;
      assign av_in  = p_av;
      assign se_in  = p_sat_e;
      assign sx_in  = p_sat_x;
    end else begin : g_next
      // The remainder stays below the divisor, so the shift cannot overflow.
      assign tag_in = (g == 1) ? t1_in : d_tag[g-1];
      assign re_in  = {d_re[g-1][DW-2:0], 1'b0};
      assign rx_in  = {d_rx[g-1][DW-2:0], 1'b0};
      assign qe_in  = d_qe[g-1];
      assign qx_in  = d_qx[g-1];
      assign av_in  = d_av[g-1];
      assign se_in  = d_se[g-1];
      assign sx_in  = d_sx[g-1];
    end

    assign avx  = {1'b0, av_in};
    assign ge_e = re_in >= avx;
    assign ge_x = rx_in >= avx;

    always_ff @(posedge clk) begin
      if (rst) begin
        d_tag[g] <= '0;
      end else if (en) begin
        d_tag[g] <= tag_in;
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        d_re[g] <= ge_e ? re_in - avx : re_in;
        d_rx[g] <= ge_x ? rx_in - avx : rx_in;
        d_qe[g] <= {qe_in[NQ-2:0], ge_e};
        d_qx[g] <= {qx_in[NQ-2:0], ge_x};
        d_av[g] <= av_in;
        d_se[g] <= se_in;
        d_sx[g] <= sx_in;
      end
    end
  end

  // A saturated exit time always exceeds a valid entry time, so it is not compared.
  assign te_late = d_se[NQ-1] || (d_qe[NQ-1] > TOI_ONE) ||
                   (!d_sx[NQ-1] && (d_qe[NQ-1] > d_qx[NQ-1]));
  assign toi     = te_late ? TOI_ONE : d_qe[NQ-1];

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (en) begin
      out_valid <= d_tag[NQ-1].valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      out_data.hit            <= d_tag[NQ-1].hit;
      out_data.time_of_impact <= d_tag[NQ-1].is_swept ? toi : '0;
    end
  end

endmodule

// ===== hdl/collision_test_unit_2d_core.sv =====
// ----------------------------------------------------------------------------
// collision_test_unit_2d_core
// 2D collision query unit on signed 16.16 coordinates.
// ----------------------------------------------------------------------------
// One request is accepted every cycle while the queue is not full, and each gives
// one result, in order. From acceptance a request passes through the queue, a
// preparation stage and seventeen divider stages, after which the result
// register presents it. The depth is set by the swept test's restoring divider,
// which resolves one quotient bit per stage; distance tests run alongside it in
// the same stages. A waiting result holds the whole back pipeline, and the queue
// keeps taking requests until it is full.
`include "assert_macros.svh"

module collision_test_unit_2d_core import ctu2d_pkg::*; #(
  parameter int QUEUE_DEPTH = 4
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  ctu2d_req_t  in_data,
  output logic        out_valid,
  input  logic        out_ready,
  output ctu2d_resp_t out_data
);

  ctu2d_job_t   f_job;
  ctu2d_job_t   q_job;
  ctu2d_qstat_t q_stat;
  logic         push;
  logic         pop;

  assign in_ready = !q_stat.full;
  assign push     = in_valid && in_ready;

  ctu2d_front u_front (
    .req (in_data),
    .job (f_job)
  );

  ctu2d_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_data (f_job),
    .pop       (pop),
    .pop_data  (q_job),
    .stat      (q_stat)
  );

  ctu2d_back u_back (
    .clk       (clk),
    .rst       (rst),
    .job       (q_job),
    .qstat     (q_stat),
    .pop       (pop),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

  `CTU_ASSERT_ALWAYS(a_no_result_after_reset, $past(rst) |-> !out_valid, "result after reset")
  `CTU_ASSERT(a_push_fills, push |=> !q_stat.empty, "accepted request lost by queue")
  `CTU_ASSERT(a_hit_or_time, out_valid && out_data.time_of_impact != '0 |-> !out_data.hit, "hit with time")

endmodule

// ===== tb/testbench.sv =====
// ----------------------------------------------------------------------------
// testbench
// Drives collision queries of every kind into the 2D collision unit, predicts
// each hit flag and time of impact, and checks the results in order.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module testbench;
  import ctu2d_pkg::*;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        in_valid = 1'b0;
  logic        in_ready;
  ctu2d_req_t  in_data = '0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  ctu2d_resp_t out_data;

  int unsigned mismatches = 0;
  int unsigned send_idle = 0;
  int unsigned recv_idle = 0;
  int unsigned quiet_cycles = 0;
  localparam int unsigned QUIET_LIMIT = 5000;

  always #2 clk = ~clk;

  collision_test_unit_2d_core dut (
    .clk(clk), .rst(rst), .in_valid(in_valid), .in_ready(in_ready),
    .in_data(in_data), .out_valid(out_valid), .out_ready(out_ready),
    .out_data(out_data)
  );

  task automatic report_mismatch(string what, longint got, longint want);
    $display("mismatch %s: got %0d expected %0d", what, got, want);
    mismatches++;
  endtask

  // Floor shift by four, then square; 33-bit inputs give at most a 57-bit square.
  function automatic logic [127:0] shifted_square(longint v);
    longint s;
    logic [63:0] m;
    s = v >>> 4;
    m = (s < 0) ? -s : s;
    return {64'd0, m} * {64'd0, m};
  endfunction

  function automatic bit in_range(longint x1, longint y1, longint x2, longint y2,
                                  longint r);
    return shifted_square(x2 - x1) + shifted_square(y2 - y1) <= shifted_square(r);
  endfunction

  function automatic longint clamp_to(longint v, longint lo, longint hi);
    if (v < lo) return lo;
    if (v > hi) return hi;
    return v;
  endfunction

  function automatic ctu2d_resp_t collision_result(ctu2d_req_t q);
    ctu2d_resp_t r;
    longint ax, ay, aw, ah, bx, by, bw, bh, ed, xd;
    logic [63:0] av, te, tx, one;
    ax = q.a_x; ay = q.a_y; aw = q.a_w; ah = q.a_h;
    bx = q.b_x; by = q.b_y; bw = q.b_w; bh = q.b_h;
    one = 64'd1 << FB;
    r = '0;
    case (q.cmd)
      CMD_CIRCLES:      r.hit = in_range(ax, ay, bx, by, aw + bw);
      CMD_BOXES:        r.hit = !(ax >= bw || aw <= bx || ay >= bh || ah <= by);
      CMD_POINT_BOX:    r.hit = ax >= bx && ax < bw && ay >= by && ay < bh;
      CMD_CIRCLE_BOX:
        r.hit = in_range(ax, ay, clamp_to(ax, bx, bw), clamp_to(ay, by, bh), aw);
      CMD_POINT_CIRCLE: r.hit = in_range(ax, ay, bx, by, bw);
      CMD_SWEPT_X: begin
        if (ay == 0) begin
          r.time_of_impact = one[NQ-1:0];
        end else begin
          if (ay > 0) begin
            ed = bx - aw; xd = bw - ax;
          end else begin
            ed = bw - ax; xd = bx - aw;
          end
          av = (ay < 0) ? -ay : ay;
          te = (((ed < 0) ? -ed : ed) << FB) / av;
          tx = (((xd < 0) ? -xd : xd) << FB) / av;
          r.time_of_impact = (te > tx || te > one) ? one[NQ-1:0] : te[NQ-1:0];
        end
      end
      default: ;
    endcase
    return r;
  endfunction

  class collision_scoreboard;
    ctu2d_resp_t pending_results[$];

    function void note_query(ctu2d_req_t q);
      pending_results.push_back(collision_result(q));
    endfunction

    task check_result(ctu2d_resp_t got);
      ctu2d_resp_t want;
      if (pending_results.size() == 0) begin
        report_mismatch("unexpected result", 1, 0);
        return;
      end
      want = pending_results.pop_front();
      if (got.hit !== want.hit) report_mismatch("hit", got.hit, want.hit);
      if (got.time_of_impact !== want.time_of_impact)
        report_mismatch("time_of_impact", got.time_of_impact, want.time_of_impact);
    endtask
  endclass

  collision_scoreboard board = new();

  always @(posedge clk) begin
    if (!rst) begin
      if (in_valid && in_ready) board.note_query(in_data);
      if (out_valid && out_ready) board.check_result(out_data);
      if ((in_valid && in_ready) || (out_valid && out_ready)) quiet_cycles = 0;
      else quiet_cycles++;
      if (quiet_cycles >= QUIET_LIMIT) begin
        $display("status: fail");
        $finish;
      end
    end
  end

  // Receiver stalls at its own rate.
  always @(negedge clk) out_ready <= ($urandom_range(99) >= recv_idle);

  function automatic logic [31:0] edge_value();
    case ($urandom_range(7))
      0: return 32'h8000_0000;
      1: return 32'h7fff_ffff;
      2: return 32'd0;
      3: return 32'hffff_ffff;
      4: return $urandom;
      default: return $urandom_range(32'h0040_0000) - 32'h0020_0000;
    endcase
  endfunction

  // Valid stays high from one request to the next unless the sender idles.
  task automatic send_query(ctu2d_req_t q);
    while ($urandom_range(99) < send_idle) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= q;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    @(negedge clk);
  endtask

  function automatic ctu2d_req_t random_query();
    ctu2d_req_t q;
    q.cmd = ($urandom_range(19) == 0) ? 3'($urandom_range(7, 6)) : 3'($urandom_range(5));
    q.a_x = edge_value(); q.a_y = edge_value(); q.a_w = edge_value();
    q.a_h = edge_value(); q.b_x = edge_value(); q.b_y = edge_value();
    q.b_w = edge_value(); q.b_h = edge_value();
    if ($urandom_range(3) == 0) begin
      // Small velocity and near target so the swept time often lands in range.
      q.a_y = $urandom_range(32'h0004_0000) - 32'h0002_0000;
      q.b_x = q.a_w + $urandom_range(32'h0002_0000) - 32'h0001_0000;
      q.b_w = q.b_x + $urandom_range(32'h0004_0000);
    end
    return q;
  endfunction

  initial begin
    ctu2d_req_t q;
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Directed: every test with extreme and boundary operands.
    for (int c = 0; c < 8; c++) begin
      q = '{cmd: 3'(c), a_x: 32'sh8000_0000, a_y: 32'sh7fff_ffff,
            a_w: 32'sh7fff_ffff, a_h: 32'sh8000_0000, b_x: 32'sh7fff_ffff,
            b_y: 32'sh8000_0000, b_w: 32'sh7fff_ffff, b_h: 32'sh7fff_ffff};
      send_query(q);
      q = '{cmd: 3'(c), default: 32'sh0001_0000};
      send_query(q);
    end
    // Zero velocity, then a late entry, then an in-range entry.
    send_query('{cmd: CMD_SWEPT_X, a_x: 0, a_y: 0, a_w: 32'sh1_0000,
                 a_h: 0, b_x: 32'sh2_0000, b_y: 0, b_w: 32'sh3_0000, b_h: 0});
    send_query('{cmd: CMD_SWEPT_X, a_x: 0, a_y: 32'sh1, a_w: 32'sh1_0000,
                 a_h: 0, b_x: 32'sh9_0000, b_y: 0, b_w: 32'shA_0000, b_h: 0});
    send_query('{cmd: CMD_SWEPT_X, a_x: 0, a_y: -32'sh4_0000, a_w: 32'sh1_0000,
                 a_h: 0, b_x: -32'sh3_0000, b_y: 0, b_w: -32'sh2_0000, b_h: 0});
    // Negative radius and an inverted box.
    send_query('{cmd: CMD_CIRCLES, a_x: 0, a_y: 0, a_w: -32'sh5_0000, a_h: 0,
                 b_x: 32'sh3_0000, b_y: 0, b_w: -32'sh1_0000, b_h: 0});
    send_query('{cmd: CMD_BOXES, a_x: 32'sh5_0000, a_y: 0, a_w: 0, a_h: 32'sh5_0000,
                 b_x: 0, b_y: 0, b_w: 32'sh9_0000, b_h: 32'sh9_0000});

    for (int phase = 0; phase < 3; phase++) begin
      send_idle = (phase == 0) ? 12 : (phase == 1) ? 65 : 0;
      recv_idle = (phase == 0) ? 65 : (phase == 1) ? 12 : 0;
      repeat (480) send_query(random_query());
    end
    in_valid <= 1'b0;

    while (board.pending_results.size() != 0) @(posedge clk);
    repeat (40) @(posedge clk);
    if (mismatches == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end
endmodule
